FILE: rtl/a1enc_pkg.sv
package a1enc_pkg;

    // match modes
    localparam logic [2:0] MODE_EVERY_SEC = 3'd0;
    localparam logic [2:0] MODE_SEC       = 3'd1;
    localparam logic [2:0] MODE_MIN       = 3'd2;
    localparam logic [2:0] MODE_HOUR      = 3'd3;
    localparam logic [2:0] MODE_DATE      = 3'd4;
    localparam logic [2:0] MODE_DAY       = 3'd5;

    localparam logic [7:0] MASK_BIT  = 8'h80;
    localparam logic [7:0] SEL_BIT   = 8'h40;
    localparam logic [7:0] A1_ENABLE = 8'h01;

    localparam logic [7:0] SEC_MAX   = 8'd59;
    localparam logic [7:0] MIN_MAX   = 8'd59;
    localparam logic [7:0] HR24_MAX  = 8'd23;
    localparam logic [7:0] HR12_MAX  = 8'd12;
    localparam logic [7:0] HR12_MIN  = 8'd1;
    localparam logic [7:0] WDAY_MIN  = 8'd1;
    localparam logic [7:0] WDAY_MAX  = 8'd7;
    localparam logic [7:0] MDAY_MIN  = 8'd1;
    localparam logic [7:0] MDAY_MAX  = 8'd31;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] alarm_seconds;
        logic [7:0] alarm_minutes;
        logic [7:0] alarm_hours;
        logic [7:0] alarm_weekday;
        logic [7:0] alarm_monthday;
        logic [7:0] prior_seconds_byte;
        logic [7:0] prior_minutes_byte;
        logic [7:0] prior_hours_byte;
        logic [7:0] prior_daydate_byte;
        logic [7:0] prior_control_byte;
    } t_req;

    typedef struct packed {
        logic [7:0] seconds_byte;
        logic [7:0] minutes_byte;
        logic [7:0] hours_byte;
        logic [7:0] daydate_byte;
        logic [7:0] control_byte;
        logic       mode_error;
    } t_rsp;

    // saturate to [lo, hi]
    function automatic logic [7:0] clamp8(input logic [7:0] v,
                                          input logic [7:0] lo,
                                          input logic [7:0] hi);
        logic [7:0] r;
        begin
            if (v > hi) begin
                r = hi;
            end else if (v < lo) begin
                r = lo;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

    // packed BCD of a value already clamped to 0..59
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [2:0] tens;
        logic [7:0] rem;
        begin
            if (v >= 8'd50) begin
                tens = 3'd5;
            end else if (v >= 8'd40) begin
                tens = 3'd4;
            end else if (v >= 8'd30) begin
                tens = 3'd3;
            end else if (v >= 8'd20) begin
                tens = 3'd2;
            end else if (v >= 8'd10) begin
                tens = 3'd1;
            end else begin
                tens = 3'd0;
            end
            rem = v - 8'(tens) * 8'd10;
            return {1'b0, tens, rem[3:0]};
        end
    endfunction

endpackage

FILE: rtl/a1enc_encode.sv
module a1enc_encode
    import a1enc_pkg::*;
(
    input  logic i_twelve_hour_mode,
    input  t_req i_req,
    output t_rsp o_rsp
);

    logic [7:0] sec_c, min_c, hr_c, wday_c, mday_c;
    logic [7:0] sec_bcd, min_bcd, hr_bcd, wday_bcd, mday_bcd;

    always_comb begin
        sec_c  = clamp8(i_req.alarm_seconds, 8'd0, SEC_MAX);
        min_c  = clamp8(i_req.alarm_minutes, 8'd0, MIN_MAX);
        hr_c   = i_twelve_hour_mode ? clamp8(i_req.alarm_hours, HR12_MIN, HR12_MAX)
                                    : clamp8(i_req.alarm_hours, 8'd0, HR24_MAX);
        wday_c = clamp8(i_req.alarm_weekday, WDAY_MIN, WDAY_MAX);
        mday_c = clamp8(i_req.alarm_monthday, MDAY_MIN, MDAY_MAX);

        sec_bcd  = to_bcd(sec_c);
        min_bcd  = to_bcd(min_c);
        hr_bcd   = to_bcd(hr_c) | (i_twelve_hour_mode ? SEL_BIT : 8'h00);
        wday_bcd = to_bcd(wday_c) | SEL_BIT;
        mday_bcd = to_bcd(mday_c);
    end

    always_comb begin
        o_rsp.seconds_byte = i_req.prior_seconds_byte;
        o_rsp.minutes_byte = i_req.prior_minutes_byte;
        o_rsp.hours_byte   = i_req.prior_hours_byte;
        o_rsp.daydate_byte = i_req.prior_daydate_byte;
        o_rsp.control_byte = i_req.prior_control_byte | A1_ENABLE;
        o_rsp.mode_error   = 1'b0;
        unique case (i_req.cmd)
            MODE_EVERY_SEC: begin
                o_rsp.seconds_byte = i_req.prior_seconds_byte | MASK_BIT;
                o_rsp.minutes_byte = i_req.prior_minutes_byte | MASK_BIT;
                o_rsp.hours_byte   = i_req.prior_hours_byte | MASK_BIT;
                o_rsp.daydate_byte = i_req.prior_daydate_byte | MASK_BIT;
            end
            MODE_SEC: begin
                o_rsp.seconds_byte = sec_bcd;
                o_rsp.minutes_byte = i_req.prior_minutes_byte | MASK_BIT;
                o_rsp.hours_byte   = i_req.prior_hours_byte | MASK_BIT;
                o_rsp.daydate_byte = i_req.prior_daydate_byte | MASK_BIT;
            end
            MODE_MIN: begin
                o_rsp.seconds_byte = sec_bcd;
                o_rsp.minutes_byte = min_bcd;
                o_rsp.hours_byte   = i_req.prior_hours_byte | MASK_BIT;
                o_rsp.daydate_byte = i_req.prior_daydate_byte | MASK_BIT;
            end
            MODE_HOUR: begin
                o_rsp.seconds_byte = sec_bcd;
                o_rsp.minutes_byte = min_bcd;
                o_rsp.hours_byte   = hr_bcd;
                o_rsp.daydate_byte = i_req.prior_daydate_byte | MASK_BIT;
            end
            MODE_DATE: begin
                o_rsp.seconds_byte = sec_bcd;
                o_rsp.minutes_byte = min_bcd;
                o_rsp.hours_byte   = hr_bcd;
                o_rsp.daydate_byte = mday_bcd;
            end
            MODE_DAY: begin
                o_rsp.seconds_byte = sec_bcd;
                o_rsp.minutes_byte = min_bcd;
                o_rsp.hours_byte   = hr_bcd;
                o_rsp.daydate_byte = wday_bcd;
            end
            default: begin
                // bad mode: everything passes through, enable untouched
                o_rsp.control_byte = i_req.prior_control_byte;
                o_rsp.mode_error   = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/alarm1_register_encoder.sv
// Alarm-1 register encoder. Each accepted word carries a match mode, the
// alarm time in binary and the four alarm register bytes plus the control
// byte as read back; one result word comes out per input word, in order.
// Time fields saturate to their legal ranges (hours 1..12 when
// twelve_hour_mode is set, else 0..23), are packed as BCD, and bit 7 masks
// are set per mode; date and day modes leave bit 7 of the day/date byte
// clear. Bit 0 of the control byte is set in modes 0..5. Modes 6 and 7
// raise o_mode_error and pass the prior bytes through untouched. Timing: a
// word is registered on input, encoded by one level of clamp/BCD logic, and
// registered on output; a new word is taken every cycle unless i_stall backs up a full pipe.
// Write twelve_hour_mode (i_cfg_we/i_cfg_wdata) only while no word is in
// flight.
module alarm1_register_encoder
    import a1enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_alarm_seconds,
    input  logic [7:0] i_alarm_minutes,
    input  logic [7:0] i_alarm_hours,
    input  logic [7:0] i_alarm_weekday,
    input  logic [7:0] i_alarm_monthday,
    input  logic [7:0] i_prior_seconds_byte,
    input  logic [7:0] i_prior_minutes_byte,
    input  logic [7:0] i_prior_hours_byte,
    input  logic [7:0] i_prior_daydate_byte,
    input  logic [7:0] i_prior_control_byte,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_seconds_byte,
    output logic [7:0] o_minutes_byte,
    output logic [7:0] o_hours_byte,
    output logic [7:0] o_daydate_byte,
    output logic [7:0] o_control_byte,
    output logic       o_mode_error
);

    logic r_twelve_hour_mode;

    logic r_in_valid;
    t_req r_req;
    logic r_out_valid;
    t_rsp r_rsp;
    t_rsp n_rsp;

    logic out_load;   // result register takes the encoded word
    logic in_load;    // input register is free to take a new word

    // Output stage frees up when empty or being drained this cycle.
    assign out_load = !r_out_valid || !i_stall;
    assign in_load  = !r_in_valid || out_load;
    assign o_stall  = !in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_twelve_hour_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_twelve_hour_mode <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_req.cmd                <= i_cmd;
            r_req.alarm_seconds      <= i_alarm_seconds;
            r_req.alarm_minutes      <= i_alarm_minutes;
            r_req.alarm_hours        <= i_alarm_hours;
            r_req.alarm_weekday      <= i_alarm_weekday;
            r_req.alarm_monthday     <= i_alarm_monthday;
            r_req.prior_seconds_byte <= i_prior_seconds_byte;
            r_req.prior_minutes_byte <= i_prior_minutes_byte;
            r_req.prior_hours_byte   <= i_prior_hours_byte;
            r_req.prior_daydate_byte <= i_prior_daydate_byte;
            r_req.prior_control_byte <= i_prior_control_byte;
        end
    end

    a1enc_encode u_encode (
        .i_twelve_hour_mode (r_twelve_hour_mode),
        .i_req              (r_req),
        .o_rsp              (n_rsp)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_seconds_byte = r_rsp.seconds_byte;
    assign o_minutes_byte = r_rsp.minutes_byte;
    assign o_hours_byte   = r_rsp.hours_byte;
    assign o_daydate_byte = r_rsp.daydate_byte;
    assign o_control_byte = r_rsp.control_byte;
    assign o_mode_error   = r_rsp.mode_error;

endmodule

FILE: rtl/a1enc_checker.sv
module a1enc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_seconds_byte,
    input logic [7:0] o_minutes_byte,
    input logic [7:0] o_hours_byte,
    input logic [7:0] o_daydate_byte,
    input logic [7:0] o_control_byte,
    input logic       o_mode_error
);

    // nothing left over from before reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_seconds_byte)
            && $stable(o_daydate_byte) && $stable(o_control_byte))
        else $error("stalled result changed");

    // good mode always arms the alarm
    a_enable_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_mode_error |-> o_control_byte[0])
        else $error("alarm enable not set");

    // unmasked day/date only in date/day modes, where nothing is masked
    a_mask_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_mode_error && !o_daydate_byte[7]
            |-> !o_hours_byte[7] && !o_minutes_byte[7] && !o_seconds_byte[7])
        else $error("mask bits out of order");

    // an encoded seconds byte is legal BCD
    a_sec_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_mode_error && !o_seconds_byte[7]
            |-> o_seconds_byte[6:4] <= 3'd5 && o_seconds_byte[3:0] <= 4'd9)
        else $error("seconds byte not BCD");

endmodule

bind alarm1_register_encoder a1enc_checker u_a1enc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_seconds_byte (o_seconds_byte),
    .o_minutes_byte (o_minutes_byte),
    .o_hours_byte   (o_hours_byte),
    .o_daydate_byte (o_daydate_byte),
    .o_control_byte (o_control_byte),
    .o_mode_error   (o_mode_error)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import a1enc_pkg::*;

    // cmd codes past the last match mode; the block must flag these
    localparam logic [2:0] MODE_BAD6 = 3'd6;
    localparam logic [2:0] MODE_BAD7 = 3'd7;

    localparam int RANDOM_PER_PHASE = 400;
    localparam int DRAIN_EVERY      = 100;
    localparam int TAIL_CYCLES      = 4;
    localparam int QUIET_LIMIT      = 2000;  // cycles with no handshake at all
    localparam int PRINT_CAP        = 100;

    // one directed row: register setting, request word, and the response
    // word when it is typed in by hand (typed == 0 -> use the encoder model)
    typedef struct packed {
        logic twelve;
        t_req w;
        logic typed;
        t_rsp rsp;
    } t_dir_row;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic cfg_we   = 1'b0;
    logic cfg_wdata = 1'b0;
    logic in_valid = 1'b0;
    t_req req_word = '0;
    logic rsp_stall = 1'b0;

    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_seconds_byte;
    logic [7:0] o_minutes_byte;
    logic [7:0] o_hours_byte;
    logic [7:0] o_daydate_byte;
    logic [7:0] o_control_byte;
    logic       o_mode_error;

    t_rsp     pending_rsp[$];  // register images still owed by the block
    t_dir_row dir_rows[$];
    logic     twelve_hr_now = 1'b0;  // our copy of twelve_hour_mode
    int       fail_count = 0;
    int       tx_idle_pct = 0;
    int       rx_idle_pct = 0;
    int       quiet;

    always #5 clk = ~clk;

    alarm1_register_encoder i_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_wdata          (cfg_wdata),
        .i_valid              (in_valid),
        .o_stall              (o_stall),
        .i_cmd                (req_word.cmd),
        .i_alarm_seconds      (req_word.alarm_seconds),
        .i_alarm_minutes      (req_word.alarm_minutes),
        .i_alarm_hours        (req_word.alarm_hours),
        .i_alarm_weekday      (req_word.alarm_weekday),
        .i_alarm_monthday     (req_word.alarm_monthday),
        .i_prior_seconds_byte (req_word.prior_seconds_byte),
        .i_prior_minutes_byte (req_word.prior_minutes_byte),
        .i_prior_hours_byte   (req_word.prior_hours_byte),
        .i_prior_daydate_byte (req_word.prior_daydate_byte),
        .i_prior_control_byte (req_word.prior_control_byte),
        .o_valid              (o_valid),
        .i_stall              (rsp_stall),
        .o_seconds_byte       (o_seconds_byte),
        .o_minutes_byte       (o_minutes_byte),
        .o_hours_byte         (o_hours_byte),
        .o_daydate_byte       (o_daydate_byte),
        .o_control_byte       (o_control_byte),
        .o_mode_error         (o_mode_error)
    );

    // ------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------

    function automatic logic [7:0] saturate(input logic [7:0] v, input logic [7:0] lo,
                                            input logic [7:0] hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // tens digit in the high nibble; inputs here never exceed 59
    function automatic logic [7:0] pack_bcd(input logic [7:0] v);
        logic [7:0] tens;
        logic [7:0] ones;
        tens = v / 8'd10;
        ones = v % 8'd10;
        return {tens[3:0], ones[3:0]};
    endfunction

    function automatic t_rsp encode_alarm(input t_req w, input logic twelve);
        t_rsp       r;
        logic [7:0] hr_code;
        hr_code = twelve ? (pack_bcd(saturate(w.alarm_hours, HR12_MIN, HR12_MAX)) | SEL_BIT)
                         : pack_bcd(saturate(w.alarm_hours, 8'd0, HR24_MAX));
        // start from the read-back bytes; an invalid mode leaves them alone
        r.seconds_byte = w.prior_seconds_byte;
        r.minutes_byte = w.prior_minutes_byte;
        r.hours_byte   = w.prior_hours_byte;
        r.daydate_byte = w.prior_daydate_byte;
        r.control_byte = w.prior_control_byte;
        r.mode_error   = 1'b0;
        if (w.cmd > MODE_DAY) begin
            r.mode_error = 1'b1;
        end else begin
            if (w.cmd >= MODE_SEC)
                r.seconds_byte = pack_bcd(saturate(w.alarm_seconds, 8'd0, SEC_MAX));
            if (w.cmd >= MODE_MIN)
                r.minutes_byte = pack_bcd(saturate(w.alarm_minutes, 8'd0, MIN_MAX));
            if (w.cmd >= MODE_HOUR)
                r.hours_byte = hr_code;
            if (w.cmd == MODE_DATE)
                r.daydate_byte = pack_bcd(saturate(w.alarm_monthday, MDAY_MIN, MDAY_MAX));
            else if (w.cmd == MODE_DAY)
                r.daydate_byte = pack_bcd(saturate(w.alarm_weekday, WDAY_MIN, WDAY_MAX))
                                 | SEL_BIT;
            // every field at or past the mode index is a don't-care in the match;
            // date/day modes compare everything, so no mask at all there
            if (w.cmd < MODE_DATE) begin
                if (w.cmd <= MODE_EVERY_SEC) r.seconds_byte |= MASK_BIT;
                if (w.cmd <= MODE_SEC)       r.minutes_byte |= MASK_BIT;
                if (w.cmd <= MODE_MIN)       r.hours_byte   |= MASK_BIT;
                r.daydate_byte |= MASK_BIT;
            end
            r.control_byte |= A1_ENABLE;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random request words
    // ------------------------------------------------------------------

    // weighted toward the clamp edges, with a good share of raw bytes
    function automatic logic [7:0] pick_time(input int top);
        logic [7:0] v;
        case ($urandom_range(9))
            0, 1, 2: v = 8'($urandom);
            3:       v = 8'(top);
            4:       v = 8'(top + 1);
            5:       v = 8'd0;
            6:       v = 8'd1;
            default: v = 8'($urandom_range(top));
        endcase
        return v;
    endfunction

    function automatic t_req random_req();
        t_req w;
        // roughly one in ten words carries a bad mode
        if ($urandom_range(9) == 0)
            w.cmd = $urandom_range(1) ? MODE_BAD6 : MODE_BAD7;
        else
            w.cmd = 3'($urandom_range(5));
        w.alarm_seconds      = pick_time(59);
        w.alarm_minutes      = pick_time(59);
        w.alarm_hours        = pick_time($urandom_range(1) ? 12 : 23);
        w.alarm_weekday      = pick_time(7);
        w.alarm_monthday     = pick_time(31);
        w.prior_seconds_byte = 8'($urandom);
        w.prior_minutes_byte = 8'($urandom);
        w.prior_hours_byte   = 8'($urandom);
        w.prior_daydate_byte = 8'($urandom);
        w.prior_control_byte = 8'($urandom);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. All tasks are entered and left right after a rising edge.
    // ------------------------------------------------------------------

    // Idle at random, then hold the word until the block takes it. valid is
    // left high on return; the next caller either reuses it or drops it.
    task automatic send_word(input t_req w, input t_rsp want);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_word <= w;
        @(posedge clk);
        while (o_stall) @(posedge clk);
        pending_rsp.push_back(want);
    endtask

    // Stop sending and wait for every owed response, plus a short tail.
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Only called on an idle block, right after drain_block.
    task automatic set_twelve_hour(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we        <= 1'b0;
        twelve_hr_now  = v;
    endtask

    task automatic add_row(input logic twelve, input t_req w, input logic typed,
                           input t_rsp rsp);
        t_dir_row row;
        row.twelve = twelve;
        row.w      = w;
        row.typed  = typed;
        row.rsp    = rsp;
        dir_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall and the checker
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
            $display("[%0t] %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic compare_byte(input string name, input logic [7:0] got,
                                input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %h, want %h", name, got, want));
    endtask

    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && o_valid === 1'b1 && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("response word with nothing outstanding");
            end else begin
                want = pending_rsp.pop_front();
                compare_byte("seconds_byte", o_seconds_byte, want.seconds_byte);
                compare_byte("minutes_byte", o_minutes_byte, want.minutes_byte);
                compare_byte("hours_byte",   o_hours_byte,   want.hours_byte);
                compare_byte("daydate_byte", o_daydate_byte, want.daydate_byte);
                compare_byte("control_byte", o_control_byte, want.control_byte);
                compare_byte("mode_error",   {7'd0, o_mode_error}, {7'd0, want.mode_error});
            end
        end
    end

    // Watchdog: a stretch with no handshake on either side means a hang.
    initial begin
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !o_stall) || (o_valid === 1'b1 && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("alarm1_register_encoder: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        t_dir_row row;
        t_req     w;
        t_rsp     want;
        logic     phase_cfg[3];

        // Directed table. Rows with typed == 1 are worked out by hand:
        // reset value, clamp extremes and the bad-mode pass-through.
        // 24-hour (reset value of the register)
        add_row(1'b0, {MODE_EVERY_SEC, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                1'b1, {8'h80, 8'h80, 8'h80, 8'h80, 8'h01, 1'b0});
        add_row(1'b0, {MODE_EVERY_SEC, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                       8'h12, 8'h34, 8'h56, 8'h78, 8'h9a}, 1'b0, '0);
        add_row(1'b0, {MODE_SEC, 8'd45, 8'd0, 8'd0, 8'd0, 8'd0,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0);
        add_row(1'b0, {MODE_SEC, 8'd60, 8'd3, 8'd3, 8'd3, 8'd3,
                       8'h00, 8'h01, 8'h02, 8'h03, 8'h04}, 1'b0, '0);
        add_row(1'b0, {MODE_MIN, 8'd59, 8'd59, 8'd9, 8'd2, 8'd2,
                       8'hc0, 8'hc0, 8'hc0, 8'hc0, 8'hc0}, 1'b0, '0);
        add_row(1'b0, {MODE_HOUR, 8'd30, 8'd7, 8'd24, 8'd4, 8'd4,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0);
        // date/day modes: low clamp bounds, bit 7 of day/date must drop
        add_row(1'b0, {MODE_DATE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                       8'hff, 8'hff, 8'hff, 8'hff, 8'hfe},
                1'b1, {8'h00, 8'h00, 8'h00, 8'h01, 8'hff, 1'b0});
        add_row(1'b0, {MODE_DAY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                1'b1, {8'h00, 8'h00, 8'h00, 8'h41, 8'h01, 1'b0});
        // high clamp bounds
        add_row(1'b0, {MODE_DAY, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                       8'hff, 8'hff, 8'hff, 8'hff, 8'h80},
                1'b1, {8'h59, 8'h59, 8'h23, 8'h47, 8'h81, 1'b0});
        add_row(1'b0, {MODE_DATE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                1'b1, {8'h59, 8'h59, 8'h23, 8'h31, 8'h01, 1'b0});
        add_row(1'b0, {MODE_DATE, 8'd5, 8'd6, 8'd7, 8'd8, 8'd31,
                       8'h80, 8'h80, 8'h80, 8'h80, 8'h80}, 1'b0, '0);
        add_row(1'b0, {MODE_DAY, 8'd1, 8'd2, 8'd3, 8'd7, 8'd15,
                       8'h80, 8'h80, 8'h80, 8'h80, 8'h01}, 1'b0, '0);
        // bad modes pass the read-back bytes through, enable bit untouched
        add_row(1'b0, {MODE_BAD6, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                       8'ha5, 8'h5a, 8'h3c, 8'hc3, 8'hfe},
                1'b1, {8'ha5, 8'h5a, 8'h3c, 8'hc3, 8'hfe, 1'b1});
        add_row(1'b0, {MODE_BAD7, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                       8'hff, 8'hff, 8'hff, 8'hff, 8'h00},
                1'b1, {8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 1'b1});
        // 12-hour: hours pin to 1..12 with bit 6 set, PM bit never set
        add_row(1'b1, {MODE_HOUR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                1'b1, {8'h00, 8'h00, 8'h41, 8'h80, 8'h01, 1'b0});
        add_row(1'b1, {MODE_HOUR, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                1'b1, {8'h59, 8'h59, 8'h52, 8'h80, 8'h01, 1'b0});
        add_row(1'b1, {MODE_DAY, 8'd10, 8'd20, 8'd13, 8'd3, 8'd20,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0);
        add_row(1'b1, {MODE_EVERY_SEC, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                       8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f},
                1'b1, {8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 1'b0});
        add_row(1'b1, {MODE_BAD6, 8'd12, 8'd12, 8'd12, 8'd12, 8'd12,
                       8'h11, 8'h22, 8'h33, 8'h44, 8'h55},
                1'b1, {8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 1'b1});
        add_row(1'b1, {MODE_MIN, 8'd12, 8'd34, 8'd11, 8'd1, 8'd1,
                       8'h0f, 8'hf0, 8'h0f, 8'hf0, 8'h0f}, 1'b0, '0);
        // back to 24-hour
        add_row(1'b0, {MODE_HOUR, 8'd59, 8'd59, 8'd23, 8'd1, 8'd1,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0);
        add_row(1'b0, {MODE_DATE, 8'd9, 8'd10, 8'd19, 8'd0, 8'd32,
                       8'h55, 8'haa, 8'h55, 8'haa, 8'h55}, 1'b0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed pass, light random idling on both sides
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.twelve != twelve_hr_now) begin
                drain_block();
                set_twelve_hour(row.twelve);
            end
            want = row.typed ? row.rsp : encode_alarm(row.w, twelve_hr_now);
            send_word(row.w, want);
        end

        // Random phases: slow receiver, then slow sender, then full rate.
        // The register is rewritten at each phase boundary and now and then inside a
        // phase, always on an empty pipe.
        phase_cfg[0] = 1'b1;
        phase_cfg[1] = 1'b0;
        phase_cfg[2] = 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 18; rx_idle_pct = 84; end
                1:       begin tx_idle_pct = 84; rx_idle_pct = 18; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            drain_block();
            set_twelve_hour(phase_cfg[phase]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // sender holds off until the block has answered everything
                if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
                    drain_block();
                    if ($urandom_range(1))
                        set_twelve_hour(1'($urandom_range(1)));
                end
                w = random_req();
                send_word(w, encode_alarm(w, twelve_hr_now));
            end
        end

        drain_block();
        if (fail_count == 0)
            $display("alarm1_register_encoder: match");
        else
            $display("alarm1_register_encoder: mismatch");
        $finish;
    end

endmodule
